// ----- rtl/mma_pkg.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate package
// Shared constants, codes and the structs that pass between the blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mma_pkg;

	// Default largest matrix dimension.
	localparam int MAX_DIM_DEF = 16;

	// Field widths that the interface fixes.
	localparam int DIM_REG_W = 5;
	localparam int IDX_PORT_W = 4;
	localparam int VALUE_W = 32;
	localparam int ACC_W = 64;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Output queue sizing.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	// Register reset values.
	localparam logic [DIM_REG_W-1:0] TOTAL_ROWS_RST = 5'd16;
	localparam logic [DIM_REG_W-1:0] INNER_DIM_RST = 5'd16;
	localparam logic [DIM_REG_W-1:0] OUT_COLS_RST = 5'd16;
	localparam logic [DIM_REG_W-1:0] NODE_COUNT_RST = 5'd1;

	// Item operations.
	typedef enum logic [1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_B = 2'd1,
		OP_COMPUTE = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_TOTAL_ROWS = 2'd0,
		REG_INNER_DIM  = 2'd1,
		REG_OUT_COLS   = 2'd2,
		REG_NODE_COUNT = 2'd3
	} reg_idx_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	// Raw register contents.
	typedef struct packed {
		logic [DIM_REG_W-1:0] total_rows;
		logic [DIM_REG_W-1:0] inner_dim;
		logic [DIM_REG_W-1:0] out_cols;
		logic [DIM_REG_W-1:0] node_count;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic a_wr;      // store item value into A
		logic b_wr;      // store item value into B
		logic res_rd;    // read the result store
		logic acc_load;  // load the accumulator from that read
		logic res_wr;    // write the result store
		logic res_zero;  // write zero instead of the accumulator
		logic ab_rd;     // issue one operand pair into the MAC pipe
		logic rsp;       // emit a result beat
		logic rsp_bad;   // that beat reports an index out of range
		logic rsp_read;  // that beat carries the result store read data
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic room;       // output queue can take one more beat
		logic pipe_busy;  // MAC pipe still holds operands or products
	} sts_t;

	// One queued result beat.
	typedef struct packed {
		logic [ACC_W-1:0] read_value;
		logic [1:0]       status;
	} rsp_t;

endpackage

// ----- rtl/mma_regs.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate configuration registers
// APB register file holding the four dimension registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mma_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [mma_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [mma_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	output mma_pkg::cfg_t                       cfg
);

	mma_pkg::cfg_t      cfg_q;
	mma_pkg::reg_idx_t  idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx = mma_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en = psel & penable & pwrite & pready;
	assign cfg = cfg_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_rows <= mma_pkg::TOTAL_ROWS_RST;
			cfg_q.inner_dim <= mma_pkg::INNER_DIM_RST;
			cfg_q.out_cols <= mma_pkg::OUT_COLS_RST;
			cfg_q.node_count <= mma_pkg::NODE_COUNT_RST;
		end else if (wr_en) begin
			unique case (idx)
				mma_pkg::REG_TOTAL_ROWS: cfg_q.total_rows <= pwdata[mma_pkg::DIM_REG_W-1:0];
				mma_pkg::REG_INNER_DIM:  cfg_q.inner_dim <= pwdata[mma_pkg::DIM_REG_W-1:0];
				mma_pkg::REG_OUT_COLS:   cfg_q.out_cols <= pwdata[mma_pkg::DIM_REG_W-1:0];
				mma_pkg::REG_NODE_COUNT: cfg_q.node_count <= pwdata[mma_pkg::DIM_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		prdata = '0;
		unique case (idx)
			mma_pkg::REG_TOTAL_ROWS: prdata = mma_pkg::APB_DATA_W'(cfg_q.total_rows);
			mma_pkg::REG_INNER_DIM:  prdata = mma_pkg::APB_DATA_W'(cfg_q.inner_dim);
			mma_pkg::REG_OUT_COLS:   prdata = mma_pkg::APB_DATA_W'(cfg_q.out_cols);
			mma_pkg::REG_NODE_COUNT: prdata = mma_pkg::APB_DATA_W'(cfg_q.node_count);
			default:                 prdata = '0;
		endcase
	end

endmodule

// ----- rtl/mma_out_fifo.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate result queue
// Small queue that decouples result beats from the downstream stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_out_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  mma_pkg::rsp_t                     push_data,
	output logic                              result_valid,
	input  logic                              result_stall,
	output mma_pkg::rsp_t                     head,
	output logic [mma_pkg::FIFO_CNT_W-1:0]    count
);

	mma_pkg::rsp_t                   entry_q [mma_pkg::FIFO_DEPTH];
	logic [mma_pkg::FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [mma_pkg::FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [mma_pkg::FIFO_CNT_W-1:0]  count_q;
	logic                            pop;

	assign result_valid = (count_q != '0);
	assign pop = result_valid & ~result_stall;
	assign head = entry_q[rd_ptr_q];
	assign count = count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mma_pkg::FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mma_pkg::FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + mma_pkg::FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - mma_pkg::FIFO_CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/mma_datapath.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate datapath
// Operand and result memories, the multiply and saturating accumulate pipe,
// the sticky saturation flag and the result beat queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_datapath #(
	parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mma_pkg::cmd_t                        cmd,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   wr_addr,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_addr,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_addr,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   res_addr,
	input  logic signed [mma_pkg::VALUE_W-1:0]   value,
	output mma_pkg::sts_t                        sts,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [mma_pkg::ACC_W-1:0]     read_value,
	output logic [1:0]                           status
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int ACC_W = mma_pkg::ACC_W;
	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	logic signed [mma_pkg::VALUE_W-1:0]  a_mem [DEPTH];
	logic signed [mma_pkg::VALUE_W-1:0]  b_mem [DEPTH];
	logic [ACC_W-1:0]                    res_mem [DEPTH];

	logic signed [mma_pkg::VALUE_W-1:0]  a_s1;
	logic signed [mma_pkg::VALUE_W-1:0]  b_s1;
	logic signed [ACC_W-1:0]             prod_s2;
	logic [ACC_W-1:0]                    res_rd_q;
	logic [ACC_W-1:0]                    acc_q;
	logic                                mac_s1;
	logic                                mac_s2;
	logic                                acc_load_s1;
	logic                                sat_q;
	logic                                rsp_s1;
	logic                                rsp_bad_s1;
	logic                                rsp_read_s1;

	logic [ACC_W-1:0]                    sum;
	logic                                ovf;
	mma_pkg::rsp_t                       rsp_beat;
	mma_pkg::rsp_t                       head;
	logic [mma_pkg::FIFO_CNT_W-1:0]      fifo_count;

	// Operand memories: written by load items, read by the MAC walk.
	always_ff @(posedge clk) begin
		if (cmd.a_wr) begin
			a_mem[wr_addr] <= value;
		end
		a_s1 <= a_mem[a_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.b_wr) begin
			b_mem[wr_addr] <= value;
		end
		b_s1 <= b_mem[b_addr];
	end

	// Result memory: cleared after reset, written back after each element.
	always_ff @(posedge clk) begin
		if (cmd.res_wr) begin
			res_mem[res_addr] <= cmd.res_zero ? '0 : acc_q;
		end
		if (cmd.res_rd) begin
			res_rd_q <= res_mem[res_addr];
		end
	end

	// Product register.
	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
	end

	// Saturating add of the product into the accumulator.
	always_comb begin
		sum = acc_q + prod_s2;
		ovf = (acc_q[ACC_W-1] == prod_s2[ACC_W-1]) && (sum[ACC_W-1] != acc_q[ACC_W-1]);
	end

	always_ff @(posedge clk) begin
		if (acc_load_s1) begin
			acc_q <= res_rd_q;
		end else if (mac_s2) begin
			acc_q <= ovf ? (acc_q[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;
		end
	end

	// Pipe control, sticky saturation flag and the response stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			mac_s2 <= 1'b0;
			acc_load_s1 <= 1'b0;
			sat_q <= 1'b0;
			rsp_s1 <= 1'b0;
		end else begin
			mac_s1 <= cmd.ab_rd;
			mac_s2 <= mac_s1;
			acc_load_s1 <= cmd.acc_load;
			rsp_s1 <= cmd.rsp;
			if (mac_s2 && ovf) begin
				sat_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_bad_s1 <= cmd.rsp_bad;
		rsp_read_s1 <= cmd.rsp_read;
	end

	// Form the result beat.
	always_comb begin
		rsp_beat.read_value = (rsp_read_s1 && !rsp_bad_s1) ? res_rd_q : '0;
		if (rsp_bad_s1) begin
			rsp_beat.status = mma_pkg::ST_RANGE;
		end else if (sat_q) begin
			rsp_beat.status = mma_pkg::ST_SAT;
		end else begin
			rsp_beat.status = mma_pkg::ST_OK;
		end
	end

	mma_out_fifo u_out_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (rsp_s1),
		.push_data    (rsp_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.head         (head),
		.count        (fifo_count)
	);

	assign read_value = head.read_value;
	assign status = head.status;

	// A new item is safe only if its beat and the one in flight both fit.
	assign sts.room = ((mma_pkg::FIFO_CNT_W+1)'(fifo_count) + (mma_pkg::FIFO_CNT_W+1)'(rsp_s1))
		< (mma_pkg::FIFO_CNT_W+1)'(mma_pkg::FIFO_DEPTH);
	assign sts.pipe_busy = mac_s1 | mac_s2;

endmodule

// ----- rtl/mma_ctrl.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate controller
// Sequences the clearing pass, item handling and the compute walk over rows,
// columns and the inner dimension, and drives the datapath addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_ctrl #(
	parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mma_pkg::cfg_t                        cfg,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [1:0]                           operation,
	input  logic [mma_pkg::IDX_PORT_W-1:0]       row,
	input  logic [mma_pkg::IDX_PORT_W-1:0]       col,
	input  mma_pkg::sts_t                        sts,
	output mma_pkg::cmd_t                        cmd,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   wr_addr,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_addr,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_addr,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   res_addr
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int CNT_W = $clog2(MAX_DIM + 1);
	localparam int NUM_W = (CNT_W + 1 > mma_pkg::IDX_PORT_W + 1) ? CNT_W + 1
		: mma_pkg::IDX_PORT_W + 1;
	localparam int PROD_W = NUM_W + CNT_W;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_LOAD  = 5'b00100,
		S_MAC   = 5'b01000,
		S_DRAIN = 5'b10000
	} state_t;

	state_t              state_q;
	state_t              state_d;
	logic [ADDR_W-1:0]   clr_q;
	logic [ADDR_W-1:0]   clr_d;
	logic [IDX_W-1:0]    i_q;
	logic [IDX_W-1:0]    i_d;
	logic [IDX_W-1:0]    j_q;
	logic [IDX_W-1:0]    j_d;
	logic [IDX_W-1:0]    k_q;
	logic [IDX_W-1:0]    k_d;

	logic [CNT_W-1:0]    rows_tot;
	logic [CNT_W-1:0]    inner;
	logic [CNT_W-1:0]    cols;
	logic [CNT_W-1:0]    nodes;
	logic                accept;
	logic                a_ok;
	logic                b_ok;
	logic                rd_ok;
	logic [ADDR_W-1:0]   item_addr;
	mma_pkg::op_t        op;

	// Out-of-range register values clamp to one and to the largest dimension.
	function automatic logic [CNT_W-1:0] eff_dim(input logic [mma_pkg::DIM_REG_W-1:0] r);
		logic [CNT_W-1:0] e;
		if (r == '0) begin
			e = CNT_W'(1);
		end else if (32'(r) > MAX_DIM) begin
			e = CNT_W'(MAX_DIM);
		end else begin
			e = CNT_W'(r);
		end
		return e;
	endfunction

	// True when cnt rows fit in the local share: cnt * nodes <= total rows.
	function automatic logic rows_fit(input logic [NUM_W-1:0] cnt,
			input logic [CNT_W-1:0] n, input logic [CNT_W-1:0] t);
		return (PROD_W'(cnt) * PROD_W'(n)) <= PROD_W'(t);
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [NUM_W-1:0] r,
			input logic [NUM_W-1:0] c);
		return ADDR_W'(32'(r) * MAX_DIM + 32'(c));
	endfunction

	assign rows_tot = eff_dim(cfg.total_rows);
	assign inner = eff_dim(cfg.inner_dim);
	assign cols = eff_dim(cfg.out_cols);
	assign nodes = eff_dim(cfg.node_count);

	assign op = mma_pkg::op_t'(operation);
	assign item_stall = (state_q != S_IDLE) || !sts.room;
	assign accept = item_valid && !item_stall;

	// Index checks for the incoming item.
	assign a_ok = (NUM_W'(row) < NUM_W'(rows_tot)) && (NUM_W'(col) < NUM_W'(inner));
	assign b_ok = (NUM_W'(row) < NUM_W'(inner)) && (NUM_W'(col) < NUM_W'(cols));
	assign rd_ok = rows_fit(NUM_W'(row) + NUM_W'(1), nodes, rows_tot)
		&& (NUM_W'(col) < NUM_W'(cols));
	assign item_addr = addr_of(NUM_W'(row), NUM_W'(col));

	// Address selection.
	assign wr_addr = item_addr;
	assign a_addr = addr_of(NUM_W'(i_q), NUM_W'(k_q));
	assign b_addr = addr_of(NUM_W'(k_q), NUM_W'(j_q));

	always_comb begin
		unique case (state_q)
			S_CLEAR: res_addr = clr_q;
			S_IDLE:  res_addr = item_addr;
			default: res_addr = addr_of(NUM_W'(i_q), NUM_W'(j_q));
		endcase
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		clr_d = clr_q;
		i_d = i_q;
		j_d = j_q;
		k_d = k_q;
		cmd = '0;

		unique case (state_q)
			S_CLEAR: begin
				cmd.res_wr = 1'b1;
				cmd.res_zero = 1'b1;
				clr_d = clr_q + ADDR_W'(1);
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end

			S_IDLE: begin
				if (accept) begin
					unique case (op)
						mma_pkg::OP_WRITE_A: begin
							cmd.a_wr = a_ok;
							cmd.rsp = 1'b1;
							cmd.rsp_bad = !a_ok;
						end
						mma_pkg::OP_WRITE_B: begin
							cmd.b_wr = b_ok;
							cmd.rsp = 1'b1;
							cmd.rsp_bad = !b_ok;
						end
						mma_pkg::OP_READ: begin
							cmd.res_rd = 1'b1;
							cmd.rsp = 1'b1;
							cmd.rsp_bad = !rd_ok;
							cmd.rsp_read = 1'b1;
						end
						mma_pkg::OP_COMPUTE: begin
							i_d = '0;
							j_d = '0;
							if (rows_fit(NUM_W'(1), nodes, rows_tot)) begin
								state_d = S_LOAD;
							end else begin
								cmd.rsp = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end

			// Fetch the running sum of element (i, j).
			S_LOAD: begin
				cmd.res_rd = 1'b1;
				cmd.acc_load = 1'b1;
				k_d = '0;
				state_d = S_MAC;
			end

			// Stream one operand pair per cycle over the inner dimension.
			S_MAC: begin
				cmd.ab_rd = 1'b1;
				k_d = k_q + IDX_W'(1);
				if ((CNT_W'(k_q) + CNT_W'(1)) == inner) begin
					state_d = S_DRAIN;
				end
			end

			// Let the pipe empty, write back, then go to the next element or finish.
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					cmd.res_wr = 1'b1;
					if ((CNT_W'(j_q) + CNT_W'(1)) < cols) begin
						j_d = j_q + IDX_W'(1);
						state_d = S_LOAD;
					end else if (rows_fit(NUM_W'(i_q) + NUM_W'(2), nodes, rows_tot)) begin
						i_d = i_q + IDX_W'(1);
						j_d = '0;
						state_d = S_LOAD;
					end else begin
						cmd.rsp = 1'b1;
						state_d = S_IDLE;
					end
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			i_q <= i_d;
			j_q <= j_d;
			k_q <= k_d;
		end
	end

endmodule

// ----- rtl/matrix_multiply_accumulate.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate
// Loads signed Q16.16 matrices A and B one element per beat, adds A times B
// into a store of signed Q32.32 accumulators on a compute beat, and returns
// single result elements on read beats, one result beat for every item.
// After reset the result store is cleared, with item_stall high until that
// pass ends. Write and read items are taken one per cycle while the block
// is idle and the result queue has room; their result beat passes the
// response stage register and then the result queue. A compute item holds
// the block while, for each of rows * cols result elements, where rows is
// total_rows / node_count, it fetches the running sum, streams one inner
// term per cycle through the single 32x32 multiplier, then drains the
// multiply-accumulate pipe and writes the sum back. A four-beat result
// queue lets items keep flowing while earlier results wait on result_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_multiply_accumulate #(
	parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mma_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [mma_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [mma_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,

	// Item channel.
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [1:0]                          operation,
	input  logic [mma_pkg::IDX_PORT_W-1:0]      row,
	input  logic [mma_pkg::IDX_PORT_W-1:0]      col,
	input  logic signed [mma_pkg::VALUE_W-1:0]  value,

	// Result channel.
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [mma_pkg::ACC_W-1:0]    read_value,
	output logic [1:0]                          status
);

	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

	mma_pkg::cfg_t      cfg;
	mma_pkg::cmd_t      cmd;
	mma_pkg::sts_t      sts;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  a_addr;
	logic [ADDR_W-1:0]  b_addr;
	logic [ADDR_W-1:0]  res_addr;

	mma_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mma_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.operation  (operation),
		.row        (row),
		.col        (col),
		.sts        (sts),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.a_addr     (a_addr),
		.b_addr     (b_addr),
		.res_addr   (res_addr)
	);

	mma_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.a_addr       (a_addr),
		.b_addr       (b_addr),
		.res_addr     (res_addr),
		.value        (value),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_value   (read_value),
		.status       (status)
	);

endmodule
